[rtl/core/vgp_pkg.sv]
// Shared types, constants and codes for the voice gain and pan matrix.
package vgp_pkg;

   // Voice table
   localparam int VOICES   = 256;
   localparam int VOICE_AW = $clog2(VOICES);

   // Request/response payload widths
   localparam int MODE_W  = 3;
   localparam int VOICE_W = 8;
   localparam int VALUE_W = 16;
   localparam int GAIN_W  = 39;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 18;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic [MODE_W-1:0] MODE_RESET    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MUTE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VOLUME   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAN      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SURROUND = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_MASTER_VOLUME   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MASTER_PAN      = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MASTER_BALANCE  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MASTER_SURROUND = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_AMPLIFY         = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_STEREO_OUT      = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_REVERSE_STEREO  = 3'd6;

   // One voice table entry
   typedef struct packed {
      logic [9:0]        volume;
      logic signed [8:0] pan;
      logic              mute;
      logic              surround;
   } vgp_entry_type;

   // Master settings
   typedef struct packed {
      logic [6:0]        master_volume;
      logic signed [7:0] master_pan;
      logic signed [7:0] master_balance;
      logic              master_surround;
      logic [17:0]       amplify;
      logic              stereo_out;
      logic              reverse_stereo;
   } vgp_cfg_type;

   localparam vgp_cfg_type CFG_RESET = '{
      master_volume:   7'd64,
      master_pan:      8'sd0,
      master_balance:  8'sd0,
      master_surround: 1'b0,
      amplify:         18'd65535,
      stereo_out:      1'b1,
      reverse_stereo:  1'b0
   };

   // Flags carried down the back pipeline
   typedef struct packed {
      logic mute;
      logic surround;
   } vgp_flags_type;

   // Front sequencer states
   typedef enum logic [1:0] {
      FS_IDLE   = 2'b01,
      FS_UPDATE = 2'b10
   } vgp_fstate_type;

endpackage

[rtl/core/vgp_if.sv]
// Handshake channels: voice request, gain response and register write.
interface vgp_req_if import vgp_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [VOICE_W-1:0]        voice;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output mode, output voice, output value, input ready);
   modport sink   (input valid, input mode, input voice, input value, output ready);
endinterface

interface vgp_rsp_if import vgp_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [GAIN_W-1:0] left_gain;
   logic signed [GAIN_W-1:0] right_gain;
   logic                     muted;
   logic                     surround_on;

   modport source (output valid, output left_gain, output right_gain, output muted,
                   output surround_on, input ready);
   modport sink   (input valid, input left_gain, input right_gain, input muted,
                   input surround_on, output ready);
endinterface

interface vgp_csr_if import vgp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/voice_gain_pan_matrix.sv]
// Top level of the voice gain and pan matrix: master registers, front, queue and back.
//
// Each request updates one voice entry (volume, pan, mute or surround) or just queries it,
// and yields exactly one response with the voice's left and right target gains after the
// master volume, pan, balance, amplify, surround, mono and reverse stereo settings. The
// front takes a new request only after the previous one is written back: the voice
// table is read in the cycle of acceptance and written back in the next. A two-entry
// queue feeds an eight-stage gain pipeline, and back-pressure on the response side only
// stalls the front once the queue is full. The voice table needs no clearing pass after
// reset. Register writes are always accepted and should be made only while no request
// is in flight.
module voice_gain_pan_matrix import vgp_pkg::*; (
   input logic      clock,
   input logic      reset,
   vgp_req_if.sink  req_ch,
   vgp_rsp_if.source rsp_ch,
   vgp_csr_if.sink  csr_ch
);

   vgp_cfg_type       cfg_ff, cfg_in;
   logic              q_full;
   logic              q_valid;
   logic              pop;
   logic              push_valid;
   vgp_entry_type     push_entry;
   vgp_entry_type     q_entry;
   logic [3:0]        pending_ff, pending_in;
   logic signed [7:0] csr_s8;

   assign csr_ch.ready = 1'b1;
   assign csr_s8       = csr_ch.data[7:0];

   // Master register writes; out of range values are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_MASTER_VOLUME: begin
               if (csr_ch.data[6:0] <= 7'd64) cfg_in.master_volume = csr_ch.data[6:0];
            end
            CSR_MASTER_PAN: begin
               if (csr_s8 >= -8'sd64 && csr_s8 <= 8'sd64) cfg_in.master_pan = csr_s8;
            end
            CSR_MASTER_BALANCE: begin
               if (csr_s8 >= -8'sd64 && csr_s8 <= 8'sd64) cfg_in.master_balance = csr_s8;
            end
            CSR_MASTER_SURROUND: cfg_in.master_surround = csr_ch.data[0];
            CSR_AMPLIFY:         cfg_in.amplify         = csr_ch.data[17:0];
            CSR_STEREO_OUT:      cfg_in.stereo_out      = csr_ch.data[0];
            CSR_REVERSE_STEREO:  cfg_in.reverse_stereo  = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if ((req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_ch.valid && req_ch.ready) && (rsp_ch.valid && rsp_ch.ready)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= CFG_RESET;
         pending_ff <= '0;
      end else begin
         cfg_ff     <= cfg_in;
         pending_ff <= pending_in;
      end
   end

   vgp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   vgp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_entry    (q_entry)
   );

   vgp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

   // Front does a read then a write back, so it cannot take requests in successive cycles
   ap_front_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted during table write back");

   // A response only ever answers an outstanding request
   ap_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (pending_ff != '0))
      else $error("response with no request outstanding");

   // Muted voices give zero gains
   ap_mute_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.muted) |-> (rsp_ch.left_gain == '0 && rsp_ch.right_gain == '0))
      else $error("muted voice with nonzero gain");

endmodule

[rtl/core/vgp_front.sv]
// Front end: accepts requests, read-modify-writes the voice table, queues the entry.
module vgp_front import vgp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   vgp_req_if.sink       req,
   input  logic          q_full,
   output logic          push_valid,
   output vgp_entry_type push_entry
);

   vgp_fstate_type            state_ff, state_in;
   logic [VOICES-1:0]         valid_ff;
   vgp_entry_type             vmem_ff [VOICES];
   vgp_entry_type             rd_entry_ff;
   logic                      rd_hit_ff;
   logic [VOICE_AW-1:0]       addr_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [VOICE_AW-1:0]       rd_addr;
   logic                      accept;
   logic                      write_en;
   vgp_entry_type             old_entry;
   vgp_entry_type             new_entry;

   assign req.ready = (state_ff == FS_IDLE) && !q_full;
   assign accept    = req.valid && req.ready;
   assign write_en  = (state_ff == FS_UPDATE);

   // Clamp the voice index to the last voice
   always_comb begin
      if (32'(req.voice) > VOICES - 1) begin
         rd_addr = VOICE_AW'(VOICES - 1);
      end else begin
         rd_addr = VOICE_AW'(req.voice);
      end
   end

   // Sequencer: read on accept, write back in the following cycle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) state_in = FS_UPDATE;
         end
         FS_UPDATE: state_in = FS_IDLE;
         default:   state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (write_en) valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Voice table, registered read
   always_ff @(posedge clock) begin
      if (write_en) vmem_ff[addr_ff] <= new_entry;
      if (accept) begin
         rd_entry_ff <= vmem_ff[rd_addr];
         rd_hit_ff   <= valid_ff[rd_addr];
         addr_ff     <= rd_addr;
         mode_ff     <= req.mode;
         value_ff    <= req.value;
      end
   end

   // Apply the command; an entry never written reads as zero
   always_comb begin
      old_entry = rd_hit_ff ? rd_entry_ff : '0;
      new_entry = old_entry;
      case (mode_ff)
         MODE_RESET: begin
            new_entry.volume   = '0;
            new_entry.pan      = '0;
            new_entry.surround = 1'b0;
         end
         MODE_MUTE: new_entry.mute = (value_ff != '0);
         MODE_VOLUME: begin
            if (value_ff > 16'sd512) begin
               new_entry.volume = 10'd512;
            end else if (value_ff < 16'sd0) begin
               new_entry.volume = '0;
            end else begin
               new_entry.volume = value_ff[9:0];
            end
         end
         MODE_PAN: begin
            if (value_ff > 16'sd128) begin
               new_entry.pan = 9'sd128;
            end else if (value_ff < -16'sd128) begin
               new_entry.pan = -9'sd128;
            end else begin
               new_entry.pan = value_ff[8:0];
            end
         end
         MODE_SURROUND: new_entry.surround = (value_ff != '0);
         MODE_QUERY: ;
         default: ;
      endcase
   end

   assign push_valid = write_en;
   assign push_entry = new_entry;

endmodule

[rtl/core/vgp_queue.sv]
// Short FIFO of updated voice entries between front and back.
module vgp_queue import vgp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  vgp_entry_type push_entry,
   input  logic          pop,
   output logic          q_valid,
   output logic          q_full,
   output vgp_entry_type q_entry
);

   vgp_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_entry = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[rtl/core/vgp_back.sv]
// Back end: pipelined gain computation from queued voice entries.
module vgp_back import vgp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  vgp_cfg_type   cfg,
   input  logic          q_valid,
   input  vgp_entry_type q_entry,
   output logic          pop,
   vgp_rsp_if.source     rsp
);

   logic en;

   // Stage valids
   logic st1_valid_ff, st2_valid_ff, st3_valid_ff, st4_valid_ff;
   logic st5_valid_ff, st6_valid_ff, st7_valid_ff, rsp_valid_ff;

   // Stage flags
   vgp_flags_type st1_flags_ff, st2_flags_ff, st3_flags_ff, st4_flags_ff;
   vgp_flags_type st5_flags_ff, st6_flags_ff, st7_flags_ff;

   // Stage 1: voice gains and master matrix terms
   logic signed [9:0] pan_minus;
   logic signed [9:0] pan_plus;
   logic signed [8:0] mpan_plus;
   logic signed [8:0] mpan_minus;
   logic [17:0]       o0_ff, o1_ff;
   logic [13:0]       d_ff, c_ff;

   // Stage 2: cross products
   logic [30:0] t_do0_ff, t_co1_ff, t_co0_ff, t_do1_ff;

   // Stage 3: row sums
   logic [30:0] e0_ff, e1_ff;

   // Stage 4: balance row scaling
   logic signed [8:0] bal_pos;
   logic signed [8:0] bal_neg;
   logic [7:0]        k0;
   logic [7:0]        k1;
   logic [37:0]       s0_ff, s1_ff;

   // Stage 5: amplify partial products
   logic [36:0] p0_lo_ff, p0_hi_ff, p1_lo_ff, p1_hi_ff;

   // Stage 6: full products
   logic [55:0] p0_ff, p1_ff;

   // Stage 7: magnitudes
   logic [56:0] psum;
   logic [35:0] lmag_ff, rmag_ff, mmag_ff;

   // Output register
   logic [GAIN_W-1:0] lx, rx, mx;
   logic              rneg;
   logic [GAIN_W-1:0] left_in, right_in;
   logic [GAIN_W-1:0] left_ff, right_ff;
   logic              muted_ff, surround_ff;

   // The whole pipeline moves unless a finished response is held
   assign en  = !rsp_valid_ff || rsp.ready;
   assign pop = en && q_valid;

   assign pan_minus  = 10'sd128 - 10'(q_entry.pan);
   assign pan_plus   = 10'sd128 + 10'(q_entry.pan);
   assign mpan_plus  = 9'sd64 + 9'(cfg.master_pan);
   assign mpan_minus = 9'sd64 - 9'(cfg.master_pan);

   // Balance scales one row only when nonzero
   assign bal_pos = 9'sd64 - 9'(cfg.master_balance);
   assign bal_neg = 9'sd64 + 9'(cfg.master_balance);
   assign k0 = (cfg.master_balance > 8'sd0) ? bal_pos[7:0] : 8'd128;
   assign k1 = (cfg.master_balance < 8'sd0) ? bal_neg[7:0] : 8'd128;

   assign psum = 57'(p0_ff) + 57'(p1_ff);

   // Final selection: mute, mono, surround and reverse stereo
   always_comb begin
      lx   = GAIN_W'(lmag_ff);
      rx   = GAIN_W'(rmag_ff);
      mx   = GAIN_W'(mmag_ff);
      rneg = st7_flags_ff.surround ^ cfg.master_surround;
      if (st7_flags_ff.mute) begin
         left_in  = '0;
         right_in = '0;
      end else if (!cfg.stereo_out) begin
         left_in  = mx;
         right_in = '0;
      end else if (cfg.reverse_stereo) begin
         left_in  = rneg ? (~rx + 1'b1) : rx;
         right_in = lx;
      end else begin
         left_in  = lx;
         right_in = rneg ? (~rx + 1'b1) : rx;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
         st6_valid_ff <= 1'b0;
         st7_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         st1_valid_ff <= q_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         st5_valid_ff <= st4_valid_ff;
         st6_valid_ff <= st5_valid_ff;
         st7_valid_ff <= st6_valid_ff;
         rsp_valid_ff <= st7_valid_ff;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         o0_ff        <= 18'(q_entry.volume) * 18'(pan_minus[8:0]);
         o1_ff        <= 18'(q_entry.volume) * 18'(pan_plus[8:0]);
         d_ff         <= 14'(cfg.master_volume) * 14'(mpan_plus[7:0]);
         c_ff         <= 14'(cfg.master_volume) * 14'(mpan_minus[7:0]);
         st1_flags_ff <= '{mute: q_entry.mute, surround: q_entry.surround};
         // stage 2
         t_do0_ff     <= 31'(d_ff) * 31'(o0_ff);
         t_co1_ff     <= 31'(c_ff) * 31'(o1_ff);
         t_co0_ff     <= 31'(c_ff) * 31'(o0_ff);
         t_do1_ff     <= 31'(d_ff) * 31'(o1_ff);
         st2_flags_ff <= st1_flags_ff;
         // stage 3
         e0_ff        <= t_do0_ff + t_co1_ff;
         e1_ff        <= t_co0_ff + t_do1_ff;
         st3_flags_ff <= st2_flags_ff;
         // stage 4
         s0_ff        <= 38'(k0) * 38'(e0_ff);
         s1_ff        <= 38'(k1) * 38'(e1_ff);
         st4_flags_ff <= st3_flags_ff;
         // stage 5: split the 38 bit operand in two halves
         p0_lo_ff     <= 37'(cfg.amplify) * 37'(s0_ff[18:0]);
         p0_hi_ff     <= 37'(cfg.amplify) * 37'(s0_ff[37:19]);
         p1_lo_ff     <= 37'(cfg.amplify) * 37'(s1_ff[18:0]);
         p1_hi_ff     <= 37'(cfg.amplify) * 37'(s1_ff[37:19]);
         st5_flags_ff <= st4_flags_ff;
         // stage 6
         p0_ff        <= (56'(p0_hi_ff) << 19) + 56'(p0_lo_ff);
         p1_ff        <= (56'(p1_hi_ff) << 19) + 56'(p1_lo_ff);
         st6_flags_ff <= st5_flags_ff;
         // stage 7
         lmag_ff      <= p0_ff[55:20];
         rmag_ff      <= p1_ff[55:20];
         mmag_ff      <= psum[56:21];
         st7_flags_ff <= st6_flags_ff;
         // output
         left_ff      <= left_in;
         right_ff     <= right_in;
         muted_ff     <= st7_flags_ff.mute;
         surround_ff  <= st7_flags_ff.surround;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_gain   = left_ff;
   assign rsp.right_gain  = right_ff;
   assign rsp.muted       = muted_ff;
   assign rsp.surround_on = surround_ff;

endmodule

[dv/tb_voice_gain_pan_matrix.sv]
// Self-checking testbench for the voice gain and pan matrix, with its gain scoreboard.
module tb_voice_gain_pan_matrix;
   import vgp_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int PIPE_LATENCY = 12;
   localparam int PHASES       = 13;
   localparam int PHASE_ITEMS  = 42;

   // Command and register codes the package leaves unnamed
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
   localparam logic [CSR_AW-1:0] CSR_NONE     = 3'd7;

   // Response-side stall patterns
   localparam int RX_ALWAYS = 0;
   localparam int RX_SHORT  = 1;
   localparam int RX_LONG   = 2;

   typedef struct {
      logic signed [GAIN_W-1:0] left_gain;
      logic signed [GAIN_W-1:0] right_gain;
      logic                     muted;
      logic                     surround_on;
   } gain_result_type;

   // Voice table and master settings mirror, plus the queue of gains still owed
   class gain_scoreboard;
      int                mvol, mpan, mbal, amp;
      bit                msurround, stereo, reverse;
      logic [9:0]        vol_tab[VOICES];
      logic signed [8:0] pan_tab[VOICES];
      bit                mute_tab[VOICES];
      bit                surr_tab[VOICES];
      gain_result_type   expected_gains[$];
      int                errors, requests, responses;

      function new();
         mvol = 64; mpan = 0; mbal = 0; amp = 65535;
         msurround = 0; stereo = 1; reverse = 0;
         errors = 0; requests = 0; responses = 0;
         foreach (vol_tab[i]) begin
            vol_tab[i] = '0; pan_tab[i] = '0; mute_tab[i] = 0; surr_tab[i] = 0;
         end
      endfunction

      // Out of range master volume, pan or balance leaves the register unchanged
      function void write_register(logic [CSR_AW-1:0] index, logic [CSR_DW-1:0] data);
         int s;
         s = int'($signed(data[7:0]));
         case (index)
            CSR_MASTER_VOLUME:   if (data[6:0] <= 7'd64) mvol = int'(data[6:0]);
            CSR_MASTER_PAN:      if (s >= -64 && s <= 64) mpan = s;
            CSR_MASTER_BALANCE:  if (s >= -64 && s <= 64) mbal = s;
            CSR_MASTER_SURROUND: msurround = data[0];
            CSR_AMPLIFY:         amp = int'(data);
            CSR_STEREO_OUT:      stereo = data[0];
            CSR_REVERSE_STEREO:  reverse = data[0];
            default: ;
         endcase
      endfunction

      // Apply one request to the table and queue the gains it should return
      function void note_request(logic [MODE_W-1:0] mode, logic [VOICE_W-1:0] voice,
                                 logic signed [VALUE_W-1:0] value);
         int              v, arg;
         longint          o0, o1, d, c, k0, k1, s0, s1, lmag, rmag, tmp;
         bit              lneg, rneg;
         gain_result_type g;
         v   = int'(voice);
         arg = value;
         if (v > VOICES - 1) v = VOICES - 1;
         case (mode)
            MODE_RESET: begin
               vol_tab[v] = '0; pan_tab[v] = '0; surr_tab[v] = 0;
            end
            MODE_MUTE:     mute_tab[v] = (arg != 0);
            MODE_VOLUME:   vol_tab[v] = (arg > 512) ? 10'd512 : (arg < 0) ? 10'd0 : arg[9:0];
            MODE_PAN:      pan_tab[v] = (arg > 128) ? 9'sd128 : (arg < -128) ? -9'sd128 : arg[8:0];
            MODE_SURROUND: surr_tab[v] = (arg != 0);
            default: ;
         endcase

         // raw voice gains through the master matrix, all terms nonnegative
         o0 = longint'(vol_tab[v]) * (128 - longint'(pan_tab[v]));
         o1 = longint'(vol_tab[v]) * (128 + longint'(pan_tab[v]));
         d  = longint'(mvol) * (64 + mpan);
         c  = longint'(mvol) * (64 - mpan);
         k0 = 128;
         k1 = 128;
         if (mbal > 0) k0 = 64 - mbal;
         else if (mbal < 0) k1 = 64 + mbal;
         s0 = k0 * (d * o0 + c * o1);
         s1 = k1 * (c * o0 + d * o1);
         lmag = (longint'(amp) * s0) >> 20;
         rmag = (longint'(amp) * s1) >> 20;
         lneg = 0;
         rneg = surr_tab[v] ^ msurround;

         if (mute_tab[v]) begin
            lmag = 0; rmag = 0; rneg = 0;
         end else if (!stereo) begin
            lmag = (longint'(amp) * (s0 + s1)) >> 21;
            rmag = 0; rneg = 0;
         end else if (reverse) begin
            tmp = lmag; lmag = rmag; rmag = tmp;
            lneg = rneg; rneg = 0;
         end

         g.left_gain   = GAIN_W'(lneg ? -lmag : lmag);
         g.right_gain  = GAIN_W'(rneg ? -rmag : rmag);
         g.muted       = mute_tab[v];
         g.surround_on = surr_tab[v];
         expected_gains.push_back(g);
         requests++;
      endfunction

      function void check_response(logic signed [GAIN_W-1:0] left_gain,
                                   logic signed [GAIN_W-1:0] right_gain,
                                   logic muted, logic surround_on);
         gain_result_type want;
         if (expected_gains.size() == 0) begin
            $error("response with no request outstanding: left_gain %0d right_gain %0d",
                   left_gain, right_gain);
            errors++;
            return;
         end
         want = expected_gains.pop_front();
         responses++;
         if (left_gain !== want.left_gain) begin
            $error("left_gain: expected %0d, got %0d", want.left_gain, left_gain);
            errors++;
         end
         if (right_gain !== want.right_gain) begin
            $error("right_gain: expected %0d, got %0d", want.right_gain, right_gain);
            errors++;
         end
         if (muted !== want.muted) begin
            $error("muted: expected %0d, got %0d", want.muted, muted);
            errors++;
         end
         if (surround_on !== want.surround_on) begin
            $error("surround_on: expected %0d, got %0d", want.surround_on, surround_on);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   vgp_req_if req_ch();
   vgp_rsp_if rsp_ch();
   vgp_csr_if csr_ch();

   voice_gain_pan_matrix u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   gain_scoreboard sb;
   int  burst_left = 0;
   bit  sender_gaps = 0;
   int  settings_applied = 0;
   int  rx_mode = RX_ALWAYS;
   int  rx_stall_left = 0;
   int  rx_mode_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Sample all three channels on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.left_gain, rsp_ch.right_gain, rsp_ch.muted,
                              rsp_ch.surround_on);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.mode, req_ch.voice, req_ch.value);
         if (csr_ch.valid && csr_ch.ready)
            sb.write_register(csr_ch.index, csr_ch.data);
      end
   end

   // Response stalls: the stall pattern is redrawn at random by itself
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(RX_ALWAYS, RX_LONG);
         rx_mode_left = $urandom_range(50, 300);
      end else begin
         rx_mode_left--;
      end
      if (rx_stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         rx_stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         case (rx_mode)
            RX_SHORT: if ($urandom_range(0, 3) == 0) rx_stall_left = $urandom_range(1, 3);
            RX_LONG:  if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(4, 16);
            default: ;
         endcase
      end
   end

   // Issue one request, opening a new burst when the last one ran out, after a random gap if gaps are on
   task automatic send_request(logic [MODE_W-1:0] mode, logic [VOICE_W-1:0] voice,
                               logic signed [VALUE_W-1:0] value);
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid = 1'b1;
      req_ch.mode  = mode;
      req_ch.voice = voice;
      req_ch.value = value;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      @(negedge clock);
   endtask

   // Mostly well-formed commands on a few busy voices so that the table fills up
   task automatic random_request();
      int                        r;
      logic [MODE_W-1:0]         mode;
      logic [VOICE_W-1:0]        voice;
      logic signed [VALUE_W-1:0] value;
      r = $urandom_range(0, 99);
      voice = (r < 70) ? VOICE_W'($urandom_range(0, 7)) :
              (r < 85) ? VOICE_W'($urandom_range(248, 255)) : VOICE_W'($urandom_range(0, 255));
      value = VALUE_W'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 25) begin
         mode = MODE_VOLUME;
         if ($urandom_range(0, 9) < 8) value = VALUE_W'($urandom_range(0, 512));
      end else if (r < 45) begin
         mode = MODE_PAN;
         if ($urandom_range(0, 9) < 8) value = VALUE_W'(int'($urandom_range(0, 256)) - 128);
      end else if (r < 55) begin
         mode = MODE_MUTE;
         if ($urandom_range(0, 3) != 0) value = '0;
      end else if (r < 65) begin
         mode = MODE_SURROUND;
         if ($urandom_range(0, 1) != 0) value = '0;
      end else if (r < 85) begin
         mode = MODE_QUERY;
      end else if (r < 92) begin
         mode = MODE_RESET;
      end else begin
         mode = r[0] ? MODE_SPARE_6 : MODE_SPARE_7;
      end
      send_request(mode, voice, value);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] index, logic [CSR_DW-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(int mv, int mp, int mb, bit ms, int amp, bit st, bit rv);
      csr_write(CSR_MASTER_VOLUME, CSR_DW'(mv));
      csr_write(CSR_MASTER_PAN, CSR_DW'(mp));
      csr_write(CSR_MASTER_BALANCE, CSR_DW'(mb));
      csr_write(CSR_MASTER_SURROUND, CSR_DW'(ms));
      csr_write(CSR_AMPLIFY, CSR_DW'(amp));
      csr_write(CSR_STEREO_OUT, CSR_DW'(st));
      csr_write(CSR_REVERSE_STEREO, CSR_DW'(rv));
      csr_ch.valid = 1'b0;
   endtask

   // Every index gets a write; a quarter carry raw data, so some are ignored
   task automatic random_settings();
      int                idx;
      logic [CSR_DW-1:0] raw;
      for (idx = 0; idx <= int'(CSR_NONE); idx++) begin
         raw = CSR_DW'($urandom_range(0, 2 ** CSR_DW - 1));
         if ($urandom_range(0, 3) != 0) begin
            case (CSR_AW'(idx))
               CSR_MASTER_VOLUME:
                  raw[6:0] = ($urandom_range(0, 2) == 0) ? 7'd64 : 7'($urandom_range(0, 64));
               CSR_MASTER_PAN, CSR_MASTER_BALANCE:
                  raw[7:0] = 8'($urandom_range(0, 128) - 64);
               CSR_AMPLIFY:
                  if ($urandom_range(0, 3) == 0) raw = CSR_DW'(65536);
               default: ;
            endcase
         end
         csr_write(CSR_AW'(idx), raw);
      end
      csr_ch.valid = 1'b0;
   endtask

   // Stop issuing and let every owed response come back before touching registers
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (sb.expected_gains.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   initial begin
      sb = new();
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.mode   = MODE_QUERY;
      req_ch.voice  = '0;
      req_ch.value  = '0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = CSR_MASTER_VOLUME;
      csr_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed commands at reset settings: clamps, edge voices, flags, voice reset
      send_request(MODE_QUERY,    8'd0,   16'sd0);
      send_request(MODE_VOLUME,   8'd0,   16'sd512);
      send_request(MODE_VOLUME,   8'd255, 16'sh7FFF);
      send_request(MODE_VOLUME,   8'd1,   16'sh8000);
      send_request(MODE_PAN,      8'd0,   16'sd128);
      send_request(MODE_PAN,      8'd255, 16'sh8000);
      send_request(MODE_VOLUME,   8'd2,   16'sd300);
      send_request(MODE_PAN,      8'd2,   16'sh7FFF);
      send_request(MODE_PAN,      8'd2,   -16'sd128);
      send_request(MODE_SURROUND, 8'd0,   16'sd1);
      send_request(MODE_SURROUND, 8'd255, -16'sd1);
      send_request(MODE_MUTE,     8'd255, 16'sh8000);
      send_request(MODE_QUERY,    8'd255, 16'sd0);
      send_request(MODE_MUTE,     8'd255, 16'sd0);
      send_request(MODE_MUTE,     8'd0,   16'sd1);
      send_request(MODE_RESET,    8'd0,   16'sh5A5A);
      send_request(MODE_QUERY,    8'd0,   16'sd0);
      send_request(MODE_MUTE,     8'd0,   16'sd0);
      send_request(MODE_SPARE_6,  8'd2,   16'sh7FFF);
      send_request(MODE_SPARE_7,  8'd255, -16'sd1);
      send_request(MODE_VOLUME,   8'hAA,  16'sd511);
      send_request(MODE_VOLUME,   8'h55,  16'sd513);
      send_request(MODE_PAN,      8'h55,  16'sd129);
      send_request(MODE_PAN,      8'hAA,  -16'sd129);
      wait_drained();

      // Fixed extremes first, then random master settings
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_settings(0, 0, 0, 0, 65536, 1, 0);
            1: apply_settings(64, -64, 64, 1, 262143, 1, 0);
            2: apply_settings(64, 64, -64, 0, 0, 1, 1);
            3: apply_settings(32, 17, -5, 1, 131071, 0, 0);
            4: apply_settings(64, -3, 40, 1, 70000, 1, 1);
            5: apply_settings(64, 0, 0, 0, 65535, 0, 1);
            6: begin
               // rejected values: master settings from phase 5 must survive
               apply_settings(127, -65, -128, 1, 1, 1, 0);
               csr_write(CSR_MASTER_PAN, CSR_DW'(65));
               csr_write(CSR_MASTER_BALANCE, CSR_DW'(65));
               csr_write(CSR_NONE, '1);
               csr_ch.valid = 1'b0;
            end
            default: random_settings();
         endcase
         settings_applied++;
         sender_gaps = (phase % 3 != 1);
         repeat (PHASE_ITEMS) random_request();
         wait_drained();
      end

      $display("tb: %0d voice commands and %0d gain responses checked", sb.requests,
               sb.responses);
      $display("tb: %0d master settings covered, including mono, reverse and rejected writes",
               settings_applied + 1);
      if (sb.errors == 0 && sb.expected_gains.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(200000 * CLK_PERIOD);
      $display("tb: failure");
      $finish;
   end

endmodule
